[rtl/sst_pkg.sv]
package sst_pkg;

   // tree geometry
   localparam int LEAVES     = 1024;
   localparam int TREE_BITS  = $clog2(LEAVES);
   localparam int TREE_N     = 1 << TREE_BITS;
   localparam int ADDR_BITS  = TREE_BITS + 1;
   localparam int MEM_DEPTH  = 2 * TREE_N;
   localparam int LR_BITS    = ADDR_BITS + 1;

   // field widths
   localparam int MODE_BITS  = 2;
   localparam int INDEX_BITS = 10;
   localparam int SUM_BITS   = 26;
   localparam int END_BITS   = 11;

   localparam logic [SUM_BITS-1:0] LEAF_MAX = SUM_BITS'(65535);

   // operation codes
   localparam logic [MODE_BITS-1:0] MODE_ASSIGN = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_SUM    = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_FIND   = 2'd2;

   typedef struct packed {
      logic [MODE_BITS-1:0]  mode;
      logic [INDEX_BITS-1:0] index;
      logic [SUM_BITS-1:0]   value;
      logic [END_BITS-1:0]   range_end;
   } req_type;

   typedef struct packed {
      logic [SUM_BITS-1:0] result;
      logic                found;
   } rsp_type;

   // one write port, two read ports (both copies take the same write)
   typedef struct packed {
      logic                 we;
      logic [ADDR_BITS-1:0] waddr;
      logic [SUM_BITS-1:0]  wdata;
      logic [ADDR_BITS-1:0] raddr_a;
      logic [ADDR_BITS-1:0] raddr_b;
   } mem_req_type;

endpackage

[rtl/sst_ram.sv]
module sst_ram #(
   parameter int WIDTH = 26,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

[rtl/sst_engine.sv]
module sst_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  sst_pkg::req_type            req_data,
   output logic                        rsp_valid,
   output sst_pkg::rsp_type            rsp_data,
   output sst_pkg::mem_req_type        mem_req,
   input  logic [sst_pkg::SUM_BITS-1:0] rd_a,
   input  logic [sst_pkg::SUM_BITS-1:0] rd_b
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ASG_LEAF,
      ST_ASG_UP,
      ST_SUM_RUN,
      ST_FIND_ROOT,
      ST_FIND_CHK
   } state_type;

   localparam int AB = sst_pkg::ADDR_BITS;
   localparam int LB = sst_pkg::LR_BITS;
   localparam int SB = sst_pkg::SUM_BITS;

   state_type        state_ff;
   logic [AB-1:0]    clr_ff;
   logic [AB-1:0]    k_ff;
   logic [SB-1:0]    cur_ff;
   logic [SB-1:0]    x_ff;
   logic             first_ff;
   logic [LB-1:0]    l_ff;
   logic [LB-1:0]    r_ff;
   logic             add_l_ff;
   logic             add_r_ff;
   logic             pend_ff;
   logic [SB-1:0]    acc_ff;
   logic             done_ff;
   logic [SB-1:0]    result_ff;
   logic             found_ff;

   // combinational helpers
   logic [SB-1:0]               leaf_val;
   logic [sst_pkg::END_BITS-1:0] hi;
   logic [LB-1:0]               r_dec;
   logic [SB-1:0]               up_sum;
   logic                        go_left;
   logic [AB-1:0]               find_nk;
   logic [SB-1:0]               find_x;
   logic [SB-1:0]               acc_in;
   logic [AB-1:0]               parent;

   always_comb begin
      leaf_val = (req_data.value > sst_pkg::LEAF_MAX) ? sst_pkg::LEAF_MAX : req_data.value;
      hi = (req_data.range_end > sst_pkg::END_BITS'(sst_pkg::LEAVES))
         ? sst_pkg::END_BITS'(sst_pkg::LEAVES) : req_data.range_end;
      r_dec   = r_ff - LB'(1);
      up_sum  = cur_ff + rd_a;
      parent  = {1'b0, k_ff[AB-1:1]};
      go_left = (rd_b >= x_ff);
      find_nk = {k_ff[AB-2:0], ~go_left};
      find_x  = go_left ? x_ff : (x_ff - rd_b);
      acc_in  = acc_ff;
      if (pend_ff) begin
         acc_in = acc_ff + (add_l_ff ? rd_a : '0) + (add_r_ff ? rd_b : '0);
      end
   end

   // memory request
   always_comb begin
      mem_req = '0;
      case (state_ff)
         ST_CLEAR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = clr_ff;
         end
         ST_ASG_LEAF: begin
            mem_req.we      = 1'b1;
            mem_req.waddr   = k_ff;
            mem_req.wdata   = cur_ff;
            mem_req.raddr_a = k_ff ^ AB'(1);
         end
         ST_ASG_UP: begin
            mem_req.we      = 1'b1;
            mem_req.waddr   = parent;
            mem_req.wdata   = up_sum;
            mem_req.raddr_a = parent ^ AB'(1);
         end
         ST_SUM_RUN: begin
            mem_req.raddr_a = l_ff[AB-1:0];
            mem_req.raddr_b = r_dec[AB-1:0];
         end
         ST_FIND_ROOT: begin
            mem_req.raddr_a = AB'(1);
            mem_req.raddr_b = AB'(2);
         end
         ST_FIND_CHK: begin
            mem_req.raddr_b = {find_nk[AB-2:0], 1'b0};
         end
         default: begin
            mem_req = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         done_ff  <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + AB'(1);
               if (clr_ff == AB'(sst_pkg::MEM_DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (start) begin
                  result_ff <= '0;
                  found_ff  <= 1'b0;
                  x_ff      <= req_data.value;
                  cur_ff    <= leaf_val;
                  k_ff      <= AB'(sst_pkg::TREE_N) + AB'(req_data.index);
                  l_ff      <= LB'(sst_pkg::TREE_N) + LB'(req_data.index);
                  r_ff      <= LB'(sst_pkg::TREE_N) + LB'(hi);
                  acc_ff    <= '0;
                  pend_ff   <= 1'b0;
                  case (req_data.mode)
                     sst_pkg::MODE_ASSIGN: begin
                        if (32'(req_data.index) < sst_pkg::LEAVES) begin
                           state_ff <= ST_ASG_LEAF;
                        end else begin
                           done_ff <= 1'b1;
                        end
                     end
                     sst_pkg::MODE_SUM: begin
                        if (hi > sst_pkg::END_BITS'(req_data.index)) begin
                           state_ff <= ST_SUM_RUN;
                        end else begin
                           done_ff <= 1'b1;
                        end
                     end
                     sst_pkg::MODE_FIND: begin
                        state_ff <= ST_FIND_ROOT;
                     end
                     default: begin
                        done_ff <= 1'b1;
                     end
                  endcase
               end
            end
            ST_ASG_LEAF: begin
               state_ff <= ST_ASG_UP;
            end
            ST_ASG_UP: begin
               // parent written this cycle; stop once the root is done
               if (parent == AB'(1)) begin
                  done_ff  <= 1'b1;
                  state_ff <= ST_IDLE;
               end else begin
                  k_ff   <= parent;
                  cur_ff <= up_sum;
               end
            end
            ST_SUM_RUN: begin
               acc_ff <= acc_in;
               if (l_ff < r_ff) begin
                  add_l_ff <= l_ff[0];
                  add_r_ff <= r_ff[0];
                  pend_ff  <= 1'b1;
                  l_ff     <= (l_ff + LB'(l_ff[0])) >> 1;
                  r_ff     <= r_ff >> 1;
               end else begin
                  pend_ff   <= 1'b0;
                  result_ff <= acc_in;
                  done_ff   <= 1'b1;
                  state_ff  <= ST_IDLE;
               end
            end
            ST_FIND_ROOT: begin
               k_ff     <= AB'(1);
               first_ff <= 1'b1;
               state_ff <= ST_FIND_CHK;
            end
            ST_FIND_CHK: begin
               first_ff <= 1'b0;
               if (first_ff && (x_ff > rd_a)) begin
                  // target above total
                  result_ff <= SB'(sst_pkg::LEAVES - 1);
                  found_ff  <= 1'b0;
                  done_ff   <= 1'b1;
                  state_ff  <= ST_IDLE;
               end else if (find_nk[AB-1]) begin
                  result_ff <= SB'(find_nk[AB-2:0]);
                  found_ff  <= 1'b1;
                  done_ff   <= 1'b1;
                  state_ff  <= ST_IDLE;
               end else begin
                  k_ff <= find_nk;
                  x_ff <= find_x;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = done_ff;
   assign rsp_data.result = result_ff;
   assign rsp_data.found  = found_ff;

endmodule

[rtl/sum_segment_tree_kth_find_top.sv]
// sum segment tree with point assign, range sum and prefix-sum search
//
// request channel: a word on req_data is taken at a rising edge with start
// high and busy low. mode selects assign leaf, range sum [index, range_end)
// or find the smallest leaf whose prefix sum reaches value.
// response channel: each request gives exactly one word on rsp_data, shown
// for one cycle with rsp_valid high. the receiver cannot stall it.
//
// steps from the accepting edge to the edge that takes the response word:
//   assign   leaf write, then one parent per cycle up the path to the root
//   sum      one tree level per cycle; answered from idle for an empty range
//   find     root read, then one level per cycle; stops at the root past the total
//   unused mode answered from idle with a zero word
// one request is worked at a time; the path walk through the node memory,
// one dependent read per level, paces the work. a new request can be taken
// in the cycle rsp_valid is high.
//
// reset: a clearing pass writes zero to all 2048 node entries, with busy
// held high throughout.
module sum_segment_tree_kth_find_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  sst_pkg::req_type req_data,
   output logic             rsp_valid,
   output sst_pkg::rsp_type rsp_data
);

   sst_pkg::mem_req_type              mem_req;
   logic [sst_pkg::SUM_BITS-1:0]      rd_a;
   logic [sst_pkg::SUM_BITS-1:0]      rd_b;

   // control: clearing pass, path walks and result word
   sst_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .mem_req   (mem_req),
      .rd_a      (rd_a),
      .rd_b      (rd_b)
   );

   // two mirrored copies of the node sums give two read ports
   sst_ram #(
      .WIDTH (sst_pkg::SUM_BITS),
      .DEPTH (sst_pkg::MEM_DEPTH)
   ) u_ram_a (
      .clock (clock),
      .we    (mem_req.we),
      .waddr (mem_req.waddr),
      .wdata (mem_req.wdata),
      .raddr (mem_req.raddr_a),
      .rdata (rd_a)
   );

   sst_ram #(
      .WIDTH (sst_pkg::SUM_BITS),
      .DEPTH (sst_pkg::MEM_DEPTH)
   ) u_ram_b (
      .clock (clock),
      .we    (mem_req.we),
      .waddr (mem_req.waddr),
      .wdata (mem_req.wdata),
      .raddr (mem_req.raddr_b),
      .rdata (rd_b)
   );

endmodule

[test/tb_sum_segment_tree_kth_find_top.sv]
`timescale 1ns / 1ps

// largest value a 26-bit result field can carry
localparam longint unsigned SUM_CEIL = (64'd1 << sst_pkg::SUM_BITS) - 1;
// mode code the block answers with zeros and otherwise ignores
localparam logic [sst_pkg::MODE_BITS-1:0] MODE_UNUSED = 2'd3;

class tree_scoreboard;
   longint unsigned node_sum [0:sst_pkg::MEM_DEPTH-1];
   sst_pkg::rsp_type expected_rsp [$];
   int unsigned errors;
   int unsigned n_assign, n_sum, n_find_hit, n_find_miss, n_unused;

   function new();
      foreach (node_sum[i]) node_sum[i] = 0;
      errors = 0;
      n_assign = 0;
      n_sum = 0;
      n_find_hit = 0;
      n_find_miss = 0;
      n_unused = 0;
   endfunction

   function longint unsigned total();
      return node_sum[1];
   endfunction

   function int unsigned outstanding();
      return expected_rsp.size();
   endfunction

   // update the tree copy and queue the answer for one accepted word
   function void note_request(sst_pkg::req_type r);
      sst_pkg::rsp_type want;
      int unsigned k, hi, l, rr;
      longint unsigned acc, x;
      want = '0;
      case (r.mode)
         sst_pkg::MODE_ASSIGN: begin
            n_assign++;
            if (r.index < sst_pkg::LEAVES) begin
               k = r.index + sst_pkg::TREE_N;
               node_sum[k] = (r.value > sst_pkg::LEAF_MAX) ? sst_pkg::LEAF_MAX : r.value;
               while (k > 1) begin
                  k = k >> 1;
                  node_sum[k] = node_sum[2*k] + node_sum[2*k+1];
               end
            end
         end
         sst_pkg::MODE_SUM: begin
            n_sum++;
            hi = (r.range_end > sst_pkg::LEAVES) ? sst_pkg::LEAVES : r.range_end;
            acc = 0;
            if (hi > r.index) begin
               l = r.index + sst_pkg::TREE_N;
               rr = hi + sst_pkg::TREE_N;
               while (l < rr) begin
                  if (l & 1) begin
                     acc += node_sum[l];
                     l++;
                  end
                  if (rr & 1) begin
                     rr--;
                     acc += node_sum[rr];
                  end
                  l = l >> 1;
                  rr = rr >> 1;
               end
            end
            want.result = sst_pkg::SUM_BITS'((acc > SUM_CEIL) ? SUM_CEIL : acc);
         end
         sst_pkg::MODE_FIND: begin
            if (r.value > node_sum[1]) begin
               n_find_miss++;
               want.result = sst_pkg::SUM_BITS'(sst_pkg::LEAVES - 1);
            end else begin
               n_find_hit++;
               x = r.value;
               k = 1;
               while (k < sst_pkg::TREE_N) begin
                  if (node_sum[2*k] >= x) begin
                     k = 2 * k;
                  end else begin
                     x -= node_sum[2*k];
                     k = 2 * k + 1;
                  end
               end
               want.result = sst_pkg::SUM_BITS'(k - sst_pkg::TREE_N);
               want.found = 1'b1;
            end
         end
         default: begin
            n_unused++;
         end
      endcase
      expected_rsp.push_back(want);
   endfunction

   // compare one response word with the oldest pending answer
   function void check_response(sst_pkg::rsp_type got);
      sst_pkg::rsp_type want;
      if (expected_rsp.size() == 0) begin
         errors++;
         $display("%0t: response with none pending: expected nothing, actual result %0d found %0d",
                  $time, got.result, got.found);
         return;
      end
      want = expected_rsp.pop_front();
      if (got.result !== want.result) begin
         errors++;
         $display("%0t: result: expected %0d, actual %0d", $time, want.result, got.result);
      end
      if (got.found !== want.found) begin
         errors++;
         $display("%0t: found: expected %0d, actual %0d", $time, want.found, got.found);
      end
   endfunction
endclass

module tb_sum_segment_tree_kth_find_top;
   import sst_pkg::*;

   localparam int unsigned RANDOM_WORDS = 1700;
   // no sender gaps in the tail of the run
   localparam int unsigned CALM_TAIL    = 200;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   tree_scoreboard ledger = new();

   sum_segment_tree_kth_find_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // both channels sampled at the edge, before the block's own updates land;
   // a response always belongs to an earlier word than one taken at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) ledger.check_response(rsp_data);
         if (start && !busy) ledger.note_request(req_data);
      end
   end

   function automatic req_type make_word(logic [MODE_BITS-1:0] mode,
                                         logic [INDEX_BITS-1:0] index,
                                         logic [SUM_BITS-1:0] value,
                                         logic [END_BITS-1:0] range_end);
      req_type w;
      w.mode      = mode;
      w.index     = index;
      w.value     = value;
      w.range_end = range_end;
      return w;
   endfunction

   // present one word and hold it until the block takes it
   task automatic send_word(req_type word);
      start    <= 1'b1;
      req_data <= word;
      @(posedge clock);
      while (!(start && !busy)) @(posedge clock);
   endtask

   // sender gap; the data lines carry junk that must be ignored
   task automatic pause_sender(int unsigned cycles);
      logic [63:0] junk;
      junk = {$urandom, $urandom};
      start    <= 1'b0;
      req_data <= junk[$bits(req_type)-1:0];
      repeat (cycles) @(posedge clock);
   endtask

   // random word with a bias toward deep tree walks and real hits;
   // heavy phases pile full-scale values into the leaves
   function automatic req_type random_word(longint unsigned sum_now, bit heavy);
      req_type w;
      logic [63:0] raw;
      int unsigned pick, sel;
      raw = {$urandom, $urandom};
      w = raw[$bits(req_type)-1:0];
      pick = $urandom_range(0, 99);
      sel  = $urandom_range(0, 99);
      if (pick < (heavy ? 60 : 38)) begin
         w.mode = MODE_ASSIGN;
         if (sel < 10) w.index = '0;
         else if (sel < 20) w.index = INDEX_BITS'(LEAVES - 1);
         sel = $urandom_range(0, 99);
         if (heavy || sel < 25) w.value = SUM_BITS'($urandom_range(60000, 65535));
         else if (sel < 45) w.value = SUM_BITS'($urandom);
         else if (sel < 55) w.value = '0;
         else if (sel < 65) w.value = SUM_BITS'($urandom_range(0, 7));
         else w.value = SUM_BITS'($urandom_range(0, 65535));
      end else if (pick < (heavy ? 75 : 63)) begin
         w.mode = MODE_SUM;
         if (sel < 40) w.range_end = END_BITS'(w.index + $urandom_range(0, 64));
         else if (sel < 60) w.range_end = END_BITS'(LEAVES);
         else if (sel < 70) w.index = '0;
      end else if (pick < 95) begin
         w.mode = MODE_FIND;
         if (sel < 60) w.value = SUM_BITS'($urandom_range(0, 32'(sum_now)));
         else if (sel < 70) w.value = SUM_BITS'(sum_now + $urandom_range(0, 1));
         else if (sel < 85) w.value = SUM_BITS'($urandom_range(0, 3));
      end else begin
         w.mode = MODE_UNUSED;
      end
      return w;
   endfunction

   initial begin
      bit gaps_on;
      bit heavy;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty tree, saturation, clipping, search edges, unused mode
      send_word(make_word(MODE_FIND, 10'd0, 26'd0, 11'd0));          // zero target on empty tree
      send_word(make_word(MODE_FIND, 10'd0, 26'd1, 11'd0));          // past an empty total
      send_word(make_word(MODE_SUM, 10'd0, 26'd0, 11'd1024));
      send_word(make_word(MODE_ASSIGN, 10'd0, 26'h3FFFFFF, 11'd0));  // saturates to leaf max
      send_word(make_word(MODE_ASSIGN, 10'd1023, 26'd65535, 11'h7FF));
      send_word(make_word(MODE_ASSIGN, 10'd512, 26'd1, 11'd0));
      send_word(make_word(MODE_ASSIGN, 10'd1023, 26'd65536, 11'd0)); // just over leaf max
      send_word(make_word(MODE_SUM, 10'd0, 26'd0, 11'd1024));
      send_word(make_word(MODE_SUM, 10'd0, 26'h3FFFFFF, 11'h7FF));   // end clipped to leaf count
      send_word(make_word(MODE_SUM, 10'd5, 26'd0, 11'd5));           // empty range
      send_word(make_word(MODE_SUM, 10'd600, 26'd0, 11'd100));       // end below start
      send_word(make_word(MODE_SUM, 10'd1023, 26'd0, 11'd1024));
      send_word(make_word(MODE_SUM, 10'd1, 26'd0, 11'd1023));
      send_word(make_word(MODE_FIND, 10'd0, 26'd0, 11'd0));
      send_word(make_word(MODE_FIND, 10'd0, 26'd1, 11'd0));
      send_word(make_word(MODE_FIND, 10'd0, 26'd65536, 11'd0));
      send_word(make_word(MODE_FIND, 10'd0, 26'd65537, 11'd0));
      send_word(make_word(MODE_FIND, 10'd0, 26'd131071, 11'd0));     // exactly the total
      send_word(make_word(MODE_FIND, 10'd0, 26'd131072, 11'd0));     // one past the total
      send_word(make_word(MODE_FIND, 10'h3FF, 26'h3FFFFFF, 11'h7FF));
      send_word(make_word(MODE_UNUSED, 10'h3FF, 26'h3FFFFFF, 11'h7FF));
      send_word(make_word(MODE_ASSIGN, 10'd0, 26'd0, 11'd0));
      send_word(make_word(MODE_FIND, 10'd0, 26'd1, 11'd0));          // skips zero leaves

      // random words, gap bursts switched on and off in stretches
      gaps_on = 1'b1;
      heavy   = 1'b0;
      for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 64 == 0) gaps_on = $urandom_range(0, 2) != 0;
         heavy = (n >= 700 && n < 1100);
         send_word(random_word(ledger.total(), heavy));
         if (n < RANDOM_WORDS - CALM_TAIL && gaps_on && $urandom_range(0, 3) == 0)
            pause_sender($urandom_range(1, 10));
      end

      // drain, then leave room for any stray response
      start <= 1'b0;
      while (ledger.outstanding() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d assigns, %0d range sums, %0d unused-mode words",
               ledger.n_assign, ledger.n_sum, ledger.n_unused);
      $display("searches: %0d within the total, %0d past it", ledger.n_find_hit,
               ledger.n_find_miss);
      if (ledger.outstanding() != 0) begin
         $display("%0t: responses: expected 0 pending, actual %0d pending", $time,
                  ledger.outstanding());
      end
      if (ledger.errors == 0 && ledger.outstanding() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // watchdog: far beyond a full run with clearing pass and every gap
   initial begin
      #10_000_000;
      $display("%0t: run did not finish, %0d responses still pending", $time,
               ledger.outstanding());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[files.f]
rtl/sst_pkg.sv
rtl/sst_ram.sv
rtl/sst_engine.sv
rtl/sum_segment_tree_kth_find_top.sv
test/tb_sum_segment_tree_kth_find_top.sv
